FILE: design/cpc_pkg.sv
// Shared constants, types and command/status structs of the cuckoo placement checker.
`default_nettype none
package cpc_pkg;

    localparam int MAX_KEYS    = 1024;
    localparam int TABLE_SLOTS = 1024;
    localparam int KEY_W       = 10;
    localparam int SLOT_W      = 10;
    localparam int EP_W        = 8;
    localparam int CNT_W       = $clog2(MAX_KEYS + 1);
    localparam int SP_W        = $clog2(MAX_KEYS + 2);
    localparam int KEY_AW      = $clog2(MAX_KEYS);
    localparam int SLOT_AW     = $clog2(TABLE_SLOTS);
    localparam int CAND_W      = 2;

    typedef struct packed {
        logic [KEY_AW-1:0] key;
        logic [CAND_W-1:0] cand;
        logic [SLOT_W-1:0] slot;
    } t_frame;

    typedef struct packed {
        logic [EP_W-1:0]   ep;
        logic [KEY_AW-1:0] key;
    } t_owner;

    typedef struct packed {
        logic load;
        logic clr;
        logic clr_own;
        logic clr_vis;
        logic reject;
        logic skip;
        logic start;
        logic pop;
        logic pop_load;
        logic pair_eval;
        logic visit;
        logic take;
        logic push;
        logic unwind;
        logic fail;
        logic win;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic load_wrap;
        logic vis_wrap;
        logic full;
        logic failed;
        logic cand_done;
        logic sp_one;
        logic slot_skip;
        logic vis_hit;
        logic own_valid;
        logic stack_full;
        logic out_free;
    } t_status;

endpackage
`default_nettype wire

FILE: design/cpc_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module cpc_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [$clog2(D)-1:0] i_waddr,
    input  wire logic [W-1:0]         i_wdata,
    input  wire logic [$clog2(D)-1:0] i_raddr,
    output logic      [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

FILE: design/cpc_datapath.sv
// Datapath: key store, slot owners, visited marks, search stack and result register.
`default_nettype none
module cpc_datapath (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire cpc_pkg::t_cmd                 i_cmd,
    output cpc_pkg::t_status                   o_status,
    input  wire logic                          i_first_of_set,
    input  wire logic [cpc_pkg::SLOT_W-1:0]    i_slot_a,
    input  wire logic [cpc_pkg::SLOT_W-1:0]    i_slot_b,
    input  wire logic                          i_ready,
    output logic                               o_valid,
    output logic      [cpc_pkg::KEY_W-1:0]     o_key_index,
    output logic                               o_placed,
    output logic                               o_all_placed
);

    logic [cpc_pkg::SLOT_W-1:0]   r_a;
    logic [cpc_pkg::SLOT_W-1:0]   r_b;
    logic [cpc_pkg::CNT_W-1:0]    r_count;
    logic                         r_failed;
    logic                         r_placed;
    logic [cpc_pkg::KEY_W-1:0]    r_idx;
    logic [cpc_pkg::EP_W-1:0]     r_set_ep;
    logic [cpc_pkg::EP_W-1:0]     r_srch_ep;
    logic [cpc_pkg::SLOT_AW-1:0]  r_clr_idx;
    logic [cpc_pkg::KEY_AW-1:0]   r_top_key;
    logic [cpc_pkg::CAND_W-1:0]   r_top_cand;
    logic [cpc_pkg::SLOT_W-1:0]   r_slot;
    logic [cpc_pkg::SP_W-1:0]     r_sp;
    logic                         r_ovalid;
    logic [cpc_pkg::KEY_W-1:0]    r_okey;
    logic                         r_oplaced;
    logic                         r_oall;

    logic [2*cpc_pkg::SLOT_W-1:0] pair_q;
    cpc_pkg::t_owner              own_q;
    logic [cpc_pkg::EP_W-1:0]     vis_q;
    cpc_pkg::t_frame              stk_q;
    logic [cpc_pkg::SLOT_W-1:0]   s_pick;
    logic [cpc_pkg::SP_W-1:0]     sp_m1;
    logic [cpc_pkg::SP_W-1:0]     sp_m2;

    logic                         own_we;
    logic [cpc_pkg::SLOT_AW-1:0]  own_waddr;
    cpc_pkg::t_owner              own_wdata;
    logic                         vis_we;
    logic [cpc_pkg::SLOT_AW-1:0]  vis_waddr;
    logic [cpc_pkg::EP_W-1:0]     vis_wdata;
    cpc_pkg::t_frame              stk_wdata;

    // pick the candidate slot of the top frame
    assign s_pick = r_top_cand[0] ? pair_q[2*cpc_pkg::SLOT_W-1:cpc_pkg::SLOT_W]
                                  : pair_q[cpc_pkg::SLOT_W-1:0];
    assign sp_m1  = r_sp - cpc_pkg::SP_W'(1);
    assign sp_m2  = r_sp - cpc_pkg::SP_W'(2);

    // steer the write ports
    always_comb begin
        own_we          = (i_cmd.clr && i_cmd.clr_own) || i_cmd.take || i_cmd.unwind;
        own_wdata.ep    = r_set_ep;
        own_wdata.key   = stk_q.key;
        own_waddr       = stk_q.slot[cpc_pkg::SLOT_AW-1:0];
        if (i_cmd.clr) begin
            own_waddr = r_clr_idx;
            own_wdata = '0;
        end else if (i_cmd.take) begin
            own_waddr     = r_slot[cpc_pkg::SLOT_AW-1:0];
            own_wdata.key = r_top_key;
        end
        vis_we    = (i_cmd.clr && i_cmd.clr_vis) || i_cmd.visit;
        vis_waddr = i_cmd.clr ? r_clr_idx : r_slot[cpc_pkg::SLOT_AW-1:0];
        vis_wdata = i_cmd.clr ? '0 : r_srch_ep;
        stk_wdata.key  = r_top_key;
        stk_wdata.cand = r_top_cand;
        stk_wdata.slot = r_slot;
    end

    cpc_ram #(.W(2*cpc_pkg::SLOT_W), .D(cpc_pkg::MAX_KEYS)) u_pair_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.start),
        .i_waddr (r_count[cpc_pkg::KEY_AW-1:0]),
        .i_wdata ({r_b, r_a}),
        .i_raddr (r_top_key),
        .o_rdata (pair_q)
    );

    cpc_ram #(.W($bits(cpc_pkg::t_owner)), .D(cpc_pkg::TABLE_SLOTS)) u_owner_ram (
        .i_clk   (i_clk),
        .i_we    (own_we),
        .i_waddr (own_waddr),
        .i_wdata (own_wdata),
        .i_raddr (s_pick[cpc_pkg::SLOT_AW-1:0]),
        .o_rdata (own_q)
    );

    cpc_ram #(.W(cpc_pkg::EP_W), .D(cpc_pkg::TABLE_SLOTS)) u_visit_ram (
        .i_clk   (i_clk),
        .i_we    (vis_we),
        .i_waddr (vis_waddr),
        .i_wdata (vis_wdata),
        .i_raddr (s_pick[cpc_pkg::SLOT_AW-1:0]),
        .o_rdata (vis_q)
    );

    cpc_ram #(.W($bits(cpc_pkg::t_frame)), .D(cpc_pkg::MAX_KEYS)) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.push),
        .i_waddr (sp_m1[cpc_pkg::KEY_AW-1:0]),
        .i_wdata (stk_wdata),
        .i_raddr (sp_m2[cpc_pkg::KEY_AW-1:0]),
        .o_rdata (stk_q)
    );

    // report status to the controller
    always_comb begin
        o_status.clr_last   = (r_clr_idx == cpc_pkg::SLOT_AW'(cpc_pkg::TABLE_SLOTS - 1));
        o_status.load_wrap  = i_first_of_set && (&r_set_ep);
        o_status.vis_wrap   = &r_srch_ep;
        o_status.full       = (r_count >= cpc_pkg::CNT_W'(cpc_pkg::MAX_KEYS));
        o_status.failed     = r_failed;
        o_status.cand_done  = r_top_cand[1];
        o_status.sp_one     = (r_sp == cpc_pkg::SP_W'(1));
        o_status.slot_skip  = ({1'b0, s_pick} >=
                               (cpc_pkg::SLOT_W + 1)'(cpc_pkg::TABLE_SLOTS));
        o_status.vis_hit    = (vis_q == r_srch_ep);
        o_status.own_valid  = (own_q.ep == r_set_ep);
        o_status.stack_full = (r_sp >= cpc_pkg::SP_W'(cpc_pkg::MAX_KEYS + 1));
        o_status.out_free   = !r_ovalid || i_ready;
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_a <= i_slot_a;
            r_b <= i_slot_b;
        end
        if (i_cmd.reject || i_cmd.skip || i_cmd.start) begin
            r_idx <= r_count[cpc_pkg::KEY_W-1:0];
        end
        if (i_cmd.pair_eval) begin
            r_slot <= s_pick;
        end
        if (i_cmd.emit) begin
            r_okey    <= r_idx;
            r_oplaced <= r_placed;
            r_oall    <= !r_failed;
        end
    end

    // control registers of the search
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_failed   <= 1'b0;
            r_placed   <= 1'b0;
            r_set_ep   <= cpc_pkg::EP_W'(1);
            r_srch_ep  <= cpc_pkg::EP_W'(1);
            r_clr_idx  <= '0;
            r_top_key  <= '0;
            r_top_cand <= '0;
            r_sp       <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            // sweep the clear pointer
            if (i_cmd.clr) begin
                r_clr_idx <= o_status.clr_last ? '0 : r_clr_idx + cpc_pkg::SLOT_AW'(1);
            end
            // open a new set
            if (i_cmd.load && i_first_of_set) begin
                r_count  <= '0;
                r_failed <= 1'b0;
                r_set_ep <= (&r_set_ep) ? cpc_pkg::EP_W'(1) : r_set_ep + cpc_pkg::EP_W'(1);
            end
            if (i_cmd.reject) begin
                r_failed <= 1'b1;
                r_placed <= 1'b0;
            end
            if (i_cmd.skip) begin
                r_count  <= r_count + cpc_pkg::CNT_W'(1);
                r_placed <= 1'b0;
            end
            // begin the search with the new key on top
            if (i_cmd.start) begin
                r_srch_ep  <= (&r_srch_ep) ? cpc_pkg::EP_W'(1)
                                           : r_srch_ep + cpc_pkg::EP_W'(1);
                r_top_key  <= r_count[cpc_pkg::KEY_AW-1:0];
                r_top_cand <= '0;
                r_sp       <= cpc_pkg::SP_W'(1);
            end
            if (i_cmd.pop || i_cmd.take || i_cmd.unwind) begin
                r_sp <= sp_m1;
            end
            if (i_cmd.pop_load) begin
                r_top_key  <= stk_q.key;
                r_top_cand <= stk_q.cand;
            end
            if (i_cmd.pair_eval) begin
                r_top_cand <= r_top_cand + cpc_pkg::CAND_W'(1);
            end
            // descend into the owner of the slot
            if (i_cmd.push) begin
                r_sp       <= r_sp + cpc_pkg::SP_W'(1);
                r_top_key  <= own_q.key;
                r_top_cand <= '0;
            end
            if (i_cmd.fail) begin
                r_placed <= 1'b0;
                r_failed <= 1'b1;
                r_count  <= r_count + cpc_pkg::CNT_W'(1);
                r_sp     <= '0;
            end
            if (i_cmd.win) begin
                r_placed <= 1'b1;
                r_count  <= r_count + cpc_pkg::CNT_W'(1);
            end
            // hold the result until its transfer
            if (i_cmd.emit) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_valid      = r_ovalid;
    assign o_key_index  = r_okey;
    assign o_placed     = r_oplaced;
    assign o_all_placed = r_oall;

endmodule
`default_nettype wire

FILE: design/cpc_controller.sv
// Controller: state machine that sequences clears, search steps and result transfer.
`default_nettype none
module cpc_controller (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire cpc_pkg::t_status i_status,
    output cpc_pkg::t_cmd         o_cmd
);

    typedef enum logic [10:0] {
        S_CLR_ALL = 11'b000_0000_0001,
        S_CLR_OWN = 11'b000_0000_0010,
        S_CLR_VIS = 11'b000_0000_0100,
        S_IDLE    = 11'b000_0000_1000,
        S_CHECK   = 11'b000_0001_0000,
        S_FETCH   = 11'b000_0010_0000,
        S_POP     = 11'b000_0100_0000,
        S_PAIR    = 11'b000_1000_0000,
        S_SLOT    = 11'b001_0000_0000,
        S_UNWIND  = 11'b010_0000_0000,
        S_EMIT    = 11'b100_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_ready = (r_state == S_IDLE);

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLR_ALL: begin
                o_cmd.clr     = 1'b1;
                o_cmd.clr_own = 1'b1;
                o_cmd.clr_vis = 1'b1;
                if (i_status.clr_last) n_state = S_IDLE;
            end
            S_CLR_OWN: begin
                o_cmd.clr     = 1'b1;
                o_cmd.clr_own = 1'b1;
                if (i_status.clr_last) n_state = S_CHECK;
            end
            S_CLR_VIS: begin
                o_cmd.clr     = 1'b1;
                o_cmd.clr_vis = 1'b1;
                if (i_status.clr_last) n_state = S_FETCH;
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_status.load_wrap ? S_CLR_OWN : S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_status.full) begin
                    o_cmd.reject = 1'b1;
                    n_state      = S_EMIT;
                end else if (i_status.failed) begin
                    o_cmd.skip = 1'b1;
                    n_state    = S_EMIT;
                end else begin
                    o_cmd.start = 1'b1;
                    n_state     = i_status.vis_wrap ? S_CLR_VIS : S_FETCH;
                end
            end
            S_FETCH: begin
                if (!i_status.cand_done) begin
                    n_state = S_PAIR;
                end else if (i_status.sp_one) begin
                    o_cmd.fail = 1'b1;
                    n_state    = S_EMIT;
                end else begin
                    o_cmd.pop = 1'b1;
                    n_state   = S_POP;
                end
            end
            S_POP: begin
                o_cmd.pop_load = 1'b1;
                n_state        = S_FETCH;
            end
            S_PAIR: begin
                o_cmd.pair_eval = 1'b1;
                n_state         = i_status.slot_skip ? S_FETCH : S_SLOT;
            end
            S_SLOT: begin
                if (i_status.vis_hit) begin
                    n_state = S_FETCH;
                end else begin
                    o_cmd.visit = 1'b1;
                    if (!i_status.own_valid) begin
                        o_cmd.take = 1'b1;
                        if (i_status.sp_one) begin
                            o_cmd.win = 1'b1;
                            n_state   = S_EMIT;
                        end else begin
                            n_state = S_UNWIND;
                        end
                    end else begin
                        o_cmd.push = !i_status.stack_full;
                        n_state    = S_FETCH;
                    end
                end
            end
            S_UNWIND: begin
                o_cmd.unwind = 1'b1;
                if (i_status.sp_one) begin
                    o_cmd.win = 1'b1;
                    n_state   = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLR_ALL;
            end
        endcase
    end

    // advance the state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR_ALL;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

FILE: design/cuckoo_placement_checker.sv
// Top level of the cuckoo placement checker: controller plus datapath.
//
//   channel | handshake          | payload
//   input   | i_valid / o_ready  | i_first_of_set, i_slot_a, i_slot_b
//   result  | o_valid / i_ready  | o_key_index, o_placed, o_all_placed
//
// A key goes through accept, check and result steps, plus search steps for each
// candidate tried, each frame popped after both its candidates fail and each frame
// moved back up the chain; the search loop over the registered-read owner, visited
// and stack memories sets this. Skipped keys (after a failure or when full) take no
// search steps. The result step waits while the previous result is still held.
// After reset a pass clearing all 1024 slots runs before the first transfer; owners
// are cleared again each 255 sets and visited marks each 255 searches when an epoch
// wraps. A waiting result is held in an output register while the next key enters.
`default_nettype none
module cuckoo_placement_checker (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic                       i_first_of_set,
    input  wire logic [cpc_pkg::SLOT_W-1:0] i_slot_a,
    input  wire logic [cpc_pkg::SLOT_W-1:0] i_slot_b,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic      [cpc_pkg::KEY_W-1:0]  o_key_index,
    output logic                            o_placed,
    output logic                            o_all_placed
);

    cpc_pkg::t_cmd    cmd;
    cpc_pkg::t_status status;

    cpc_controller u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    cpc_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_first_of_set (i_first_of_set),
        .i_slot_a       (i_slot_a),
        .i_slot_b       (i_slot_b),
        .i_ready        (i_ready),
        .o_valid        (o_valid),
        .o_key_index    (o_key_index),
        .o_placed       (o_placed),
        .o_all_placed   (o_all_placed)
    );

endmodule
`default_nettype wire

FILE: design/cpc_checker.sv
// Port-level checker of the cuckoo placement checker and its bind.
`default_nettype none
module cpc_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_valid,
    input wire logic                       o_ready,
    input wire logic                       i_first_of_set,
    input wire logic [cpc_pkg::SLOT_W-1:0] i_slot_a,
    input wire logic [cpc_pkg::SLOT_W-1:0] i_slot_b,
    input wire logic                       o_valid,
    input wire logic                       i_ready,
    input wire logic [cpc_pkg::KEY_W-1:0]  o_key_index,
    input wire logic                       o_placed,
    input wire logic                       o_all_placed
);

    // a waiting key stays up, unchanged, until its transfer
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_ready |=> i_valid && $stable({i_first_of_set, i_slot_a, i_slot_b}))
        else $error("input key changed before transfer");

    // a result stays up until its transfer
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_key_index))
        else $error("result dropped before transfer");

    // a set that is still whole means this key was placed
    a_all: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_all_placed |-> o_placed)
        else $error("all_placed without placed");

    // a transfer in closes the input in the cycle after it
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("input open right after transfer");

    // reset leaves no result pending
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind cuckoo_placement_checker cpc_checker u_cpc_checker (.*);
`default_nettype wire
